// File: design/cgru_pkg.sv
// shared constants, command encodings and controller-to-datapath command struct
package cgru_pkg;

  localparam int DATA_W        = 32;
  localparam int SUM_W         = 64;
  localparam int PROD_W        = 64;
  localparam int WEIGHT_W      = 17;
  localparam int WEIGHT_FRAC   = 16;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    MUL_AS,
    MUL_AD,
    MUL_RZ,
    MUL_ZZ,
    MUL_RLO,
    MUL_RHL,
    MUL_RHH,
    MUL_ZLO,
    MUL_ZHL,
    MUL_ZHH
  } mul_sel_t;

  typedef enum logic [1:0] {
    TACC_HOLD,
    TACC_ROUND,
    TACC_ADD,
    TACC_ADD_HI
  } tacc_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     upd_r;
    logic     upd_z;
    logic     save_mrz;
    logic     save_mzz;
    tacc_op_t tacc_op;
    logic     term_rz;
    logic     term_zz;
    logic     sum_rz;
    logic     sum_zz;
    logic     out_load;
  } cgru_cmd_t;

endpackage

// File: design/cgru_if.sv
// valid/ready channel interfaces for vector entries and results
interface cgru_item_if import cgru_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] residual_in;
  logic signed [DATA_W-1:0] precond_in;
  logic signed [DATA_W-1:0] dir_in;
  logic signed [DATA_W-1:0] precond_dir_in;
  logic [WEIGHT_W-1:0]      inv_degree;
  logic                     last_item;

  modport source (
    output valid, residual_in, precond_in, dir_in, precond_dir_in, inv_degree, last_item,
    input  ready
  );
  modport sink (
    input  valid, residual_in, precond_in, dir_in, precond_dir_in, inv_degree, last_item,
    output ready
  );
endinterface

interface cgru_result_if import cgru_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] residual_out;
  logic signed [DATA_W-1:0] precond_out;
  logic signed [SUM_W-1:0]  rz_sum;
  logic signed [SUM_W-1:0]  zz_sum;
  logic                     sums_final;

  modport source (
    output valid, residual_out, precond_out, rz_sum, zz_sum, sums_final,
    input  ready
  );
  modport sink (
    input  valid, residual_out, precond_out, rz_sum, zz_sum, sums_final,
    output ready
  );
endinterface

// File: design/cgru_dp.sv
// datapath: shared 32x32 multiplier, residual updates, weighted terms and accumulators
module cgru_dp import cgru_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic signed [DATA_W-1:0] cfg_wdata,
  input  cgru_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] residual_in,
  input  logic signed [DATA_W-1:0] precond_in,
  input  logic signed [DATA_W-1:0] dir_in,
  input  logic signed [DATA_W-1:0] precond_dir_in,
  input  logic [WEIGHT_W-1:0]      inv_degree,
  input  logic                     last_item,
  output logic signed [DATA_W-1:0] residual_out,
  output logic signed [DATA_W-1:0] precond_out,
  output logic signed [SUM_W-1:0]  rz_sum,
  output logic signed [SUM_W-1:0]  zz_sum,
  output logic                     sums_final
);

  localparam logic [PROD_W-1:0] RND_DATA   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND_WEIGHT = PROD_W'(1) << (WEIGHT_FRAC - 1);
  localparam int                HH_W       = PROD_W - WEIGHT_FRAC - DATA_W;

  logic signed [DATA_W-1:0] alpha;
  logic signed [DATA_W-1:0] r_val;
  logic signed [DATA_W-1:0] z_val;
  logic signed [DATA_W-1:0] s_val;
  logic signed [DATA_W-1:0] sd_val;
  logic [WEIGHT_W-1:0]      w_val;
  logic                     last_val;
  logic signed [DATA_W-1:0] rn;
  logic signed [DATA_W-1:0] zn;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        m_rz;
  logic [PROD_W-1:0]        m_zz;
  logic [PROD_W-1:0]        tacc;
  logic signed [SUM_W-1:0]  term;
  logic signed [SUM_W-1:0]  rz_new;
  logic signed [SUM_W-1:0]  zz_new;
  logic signed [SUM_W-1:0]  rz_accum;
  logic signed [SUM_W-1:0]  zz_accum;
  logic [DATA_W-1:0]        op_a;
  logic [DATA_W-1:0]        op_b;
  logic [DATA_W-1:0]        w_ext;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  // x - round(p / 2^F) with sign neg, clamped to the data range
  function automatic logic signed [DATA_W-1:0] axpy(
    input logic signed [DATA_W-1:0] x,
    input logic [PROD_W-1:0]        p,
    input logic                     neg
  );
    logic [PROD_W-1:0]        q;
    logic signed [PROD_W+1:0] sx;
    logic signed [PROD_W+1:0] sq;
    logic signed [PROD_W+1:0] d;
    q  = (p + RND_DATA) >> FRAC_BITS;
    sx = (PROD_W+2)'(x);
    sq = signed'({2'b00, q});
    d  = neg ? (sx + sq) : (sx - sq);
    if (d[PROD_W+1:DATA_W-1] == '0 || d[PROD_W+1:DATA_W-1] == '1) begin
      return d[DATA_W-1:0];
    end
    return d[PROD_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SUM_W-1:0] from_mag(
    input logic [PROD_W-1:0] t,
    input logic              neg
  );
    if (neg) begin
      return t[PROD_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : SUM_W'(~t + 1'b1);
    end
    return t[PROD_W-1] ? {1'b0, {(SUM_W-1){1'b1}}} : SUM_W'(t);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  assign w_ext = DATA_W'(w_val);

  always_comb begin
    case (cmd.mul_sel)
      MUL_AS: begin
        op_a = mag(alpha);
        op_b = mag(s_val);
      end
      MUL_AD: begin
        op_a = mag(alpha);
        op_b = mag(sd_val);
      end
      MUL_RZ: begin
        op_a = mag(rn);
        op_b = mag(zn);
      end
      MUL_ZZ: begin
        op_a = mag(zn);
        op_b = mag(zn);
      end
      MUL_RLO: begin
        op_a = DATA_W'(m_rz[WEIGHT_FRAC-1:0]);
        op_b = w_ext;
      end
      MUL_RHL: begin
        op_a = m_rz[WEIGHT_FRAC +: DATA_W];
        op_b = w_ext;
      end
      MUL_RHH: begin
        op_a = DATA_W'(m_rz[PROD_W-1 -: HH_W]);
        op_b = w_ext;
      end
      MUL_ZLO: begin
        op_a = DATA_W'(m_zz[WEIGHT_FRAC-1:0]);
        op_b = w_ext;
      end
      MUL_ZHL: begin
        op_a = m_zz[WEIGHT_FRAC +: DATA_W];
        op_b = w_ext;
      end
      MUL_ZHH: begin
        op_a = DATA_W'(m_zz[PROD_W-1 -: HH_W]);
        op_b = w_ext;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= '0;
      rz_accum <= '0;
      zz_accum <= '0;
    end else begin
      if (cfg_we) begin
        alpha <= cfg_wdata;
      end
      if (cmd.out_load) begin
        rz_accum <= last_val ? '0 : rz_new;
        zz_accum <= last_val ? '0 : zz_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.load) begin
      r_val    <= residual_in;
      z_val    <= precond_in;
      s_val    <= dir_in;
      sd_val   <= precond_dir_in;
      w_val    <= inv_degree;
      last_val <= last_item;
    end
    if (cmd.upd_r) begin
      rn <= axpy(r_val, prod, alpha[DATA_W-1] ^ s_val[DATA_W-1]);
    end
    if (cmd.upd_z) begin
      zn <= axpy(z_val, prod, alpha[DATA_W-1] ^ sd_val[DATA_W-1]);
    end
    if (cmd.save_mrz) begin
      m_rz <= prod;
    end
    if (cmd.save_mzz) begin
      m_zz <= prod;
    end
    case (cmd.tacc_op)
      TACC_ROUND:  tacc <= (prod + RND_WEIGHT) >> WEIGHT_FRAC;
      TACC_ADD:    tacc <= tacc + prod;
      TACC_ADD_HI: tacc <= tacc + (prod << DATA_W);
      default:     tacc <= tacc;
    endcase
    if (cmd.term_rz) begin
      term <= from_mag(tacc, rn[DATA_W-1] ^ zn[DATA_W-1]);
    end else if (cmd.term_zz) begin
      term <= from_mag(tacc, 1'b0);
    end
    if (cmd.sum_rz) begin
      rz_new <= sat_add(rz_accum, term);
    end
    if (cmd.sum_zz) begin
      zz_new <= sat_add(zz_accum, term);
    end
    if (cmd.out_load) begin
      residual_out <= rn;
      precond_out  <= zn;
      rz_sum       <= rz_new;
      zz_sum       <= zz_new;
      sums_final   <= last_val;
    end
  end

endmodule

// File: design/cgru_ctrl.sv
// controller: sequences the shared multiplier and owns the output valid flag
module cgru_ctrl import cgru_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output cgru_cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_MAS  = 17'h00002,
    S_MAD  = 17'h00004,
    S_UPZ  = 17'h00008,
    S_MRZ  = 17'h00010,
    S_MZZ  = 17'h00020,
    S_RLO  = 17'h00040,
    S_RHL  = 17'h00080,
    S_RHH  = 17'h00100,
    S_RTH  = 17'h00200,
    S_RSG  = 17'h00400,
    S_ZHL  = 17'h00800,
    S_ZHH  = 17'h01000,
    S_ZTH  = 17'h02000,
    S_ZSG  = 17'h04000,
    S_ZSM  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAS;
        end
      end
      S_MAS: begin
        cmd.mul_sel = MUL_AS;
        state_next  = S_MAD;
      end
      S_MAD: begin
        cmd.mul_sel = MUL_AD;
        cmd.upd_r   = 1'b1;
        state_next  = S_UPZ;
      end
      S_UPZ: begin
        cmd.upd_z  = 1'b1;
        state_next = S_MRZ;
      end
      S_MRZ: begin
        cmd.mul_sel = MUL_RZ;
        state_next  = S_MZZ;
      end
      S_MZZ: begin
        cmd.mul_sel  = MUL_ZZ;
        cmd.save_mrz = 1'b1;
        state_next   = S_RLO;
      end
      S_RLO: begin
        cmd.mul_sel  = MUL_RLO;
        cmd.save_mzz = 1'b1;
        state_next   = S_RHL;
      end
      S_RHL: begin
        cmd.mul_sel = MUL_RHL;
        cmd.tacc_op = TACC_ROUND;
        state_next  = S_RHH;
      end
      S_RHH: begin
        cmd.mul_sel = MUL_RHH;
        cmd.tacc_op = TACC_ADD;
        state_next  = S_RTH;
      end
      S_RTH: begin
        cmd.tacc_op = TACC_ADD_HI;
        state_next  = S_RSG;
      end
      S_RSG: begin
        cmd.mul_sel = MUL_ZLO;
        cmd.term_rz = 1'b1;
        state_next  = S_ZHL;
      end
      S_ZHL: begin
        cmd.mul_sel = MUL_ZHL;
        cmd.tacc_op = TACC_ROUND;
        cmd.sum_rz  = 1'b1;
        state_next  = S_ZHH;
      end
      S_ZHH: begin
        cmd.mul_sel = MUL_ZHH;
        cmd.tacc_op = TACC_ADD;
        state_next  = S_ZTH;
      end
      S_ZTH: begin
        cmd.tacc_op = TACC_ADD_HI;
        state_next  = S_ZSG;
      end
      S_ZSG: begin
        cmd.term_zz = 1'b1;
        state_next  = S_ZSM;
      end
      S_ZSM: begin
        cmd.sum_zz = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##16 (state == S_OUT))
    else $error("accepted transaction did not reach the output step on time");

  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid raised without a load");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && cmd.out_load))
    else $error("input taken while result is being loaded");
`endif

endmodule

// File: design/cg_residual_update_two_dots_top.sv
// top level: fused residual update with two weighted running dot products
//
//   channel   direction  handshake            contents
//   items     sink       valid/ready          r, z, s, S, weight, last flag
//   results   source     valid/ready          r', z', rz sum, zz sum, final flag
//   cfg       write      cfg_we / cfg_wdata   step length alpha, signed Q16.16
//
// entries are accepted only while the sequencer is idle, so one entry is finished before
// the next is taken; the single shared 32x32 multiplier is used ten times per entry
// rst (synchronous) clears alpha, both accumulators, the sequencer and result valid
// a result waits in the output register while the next entry is accepted and worked;
// the sequencer holds in its last step until that register has been taken
module cg_residual_update_two_dots_top import cgru_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic signed [DATA_W-1:0] cfg_wdata,
  cgru_item_if.sink                items,
  cgru_result_if.source            results
);

  cgru_cmd_t cmd;

  cgru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .cmd       (cmd)
  );

  cgru_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .residual_in    (items.residual_in),
    .precond_in     (items.precond_in),
    .dir_in         (items.dir_in),
    .precond_dir_in (items.precond_dir_in),
    .inv_degree     (items.inv_degree),
    .last_item      (items.last_item),
    .residual_out   (results.residual_out),
    .precond_out    (results.precond_out),
    .rz_sum         (results.rz_sum),
    .zz_sum         (results.zz_sum),
    .sums_final     (results.sums_final)
  );

endmodule

// File: dv/cg_residual_update_two_dots_top_tb.sv
// testbench for the fused residual update with two weighted running dot products
`timescale 1ns / 100ps

module cg_residual_update_two_dots_top_tb;
  import cgru_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int IDLE_PCT = 18;
  localparam int PHASE_ITEMS = 98;
  localparam longint DATA_MAX = 64'sd2147483647;
  localparam longint DATA_MIN = -64'sd2147483648;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] r_new;
    logic signed [DATA_W-1:0] z_new;
    logic signed [SUM_W-1:0]  rz;
    logic signed [SUM_W-1:0]  zz;
    logic                     fin;
  } update_res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] sd;
    logic [WEIGHT_W-1:0]      w;
    logic                     last;
    bit                       typed;
    update_res_t              want;
  } vec_entry_t;

  typedef struct {
    bit                       set_alpha;
    logic signed [DATA_W-1:0] alpha;
    vec_entry_t               e;
  } stim_row_t;

  localparam update_res_t NO_RESULT = '0;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic signed [DATA_W-1:0] cfg_wdata;

  cgru_item_if   items_ch ();
  cgru_result_if results_ch ();

  cg_residual_update_two_dots_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .items     (items_ch),
    .results   (results_ch)
  );

  logic signed [DATA_W-1:0] step_alpha;
  logic signed [SUM_W-1:0]  rz_run;
  logic signed [SUM_W-1:0]  zz_run;
  vec_entry_t               pending_entries[$];
  update_res_t              expected_updates[$];
  stim_row_t                stim_table[$];
  vec_entry_t               cur_entry;
  update_res_t              accepted_res;
  bit                       calm;
  int                       mismatches = 0;
  int                       stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] axpy_round_sat(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] alpha,
    input logic signed [DATA_W-1:0] d
  );
    longint p;
    longint sq;
    longint r;
    longint unsigned m;
    longint unsigned q;
    p = longint'(alpha) * longint'(d);
    m = (p < 0) ? -p : p;
    q = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    sq = (p < 0) ? -longint'(q) : longint'(q);
    r = longint'(x) - sq;
    if (r > DATA_MAX) r = DATA_MAX;
    else if (r < DATA_MIN) r = DATA_MIN;
    return r[DATA_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] weighted_term(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b,
    input logic [WEIGHT_W-1:0]      w
  );
    longint p;
    longint unsigned m;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned t;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? -p : p;
    hi = m >> WEIGHT_FRAC;
    lo = m & ((64'd1 << WEIGHT_FRAC) - 64'd1);
    t = hi * w + ((lo * w + (64'd1 << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC);
    if (p < 0) return t[63] ? SUM_MIN : -longint'(t);
    return t[63] ? SUM_MAX : longint'(t);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add64(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  function automatic update_res_t predict_update(
    input vec_entry_t               e,
    input logic signed [DATA_W-1:0] alpha,
    input logic signed [SUM_W-1:0]  rz_prev,
    input logic signed [SUM_W-1:0]  zz_prev
  );
    update_res_t res;
    res.r_new = axpy_round_sat(e.r, alpha, e.s);
    res.z_new = axpy_round_sat(e.z, alpha, e.sd);
    res.rz = sat_add64(rz_prev, weighted_term(res.r_new, res.z_new, e.w));
    res.zz = sat_add64(zz_prev, weighted_term(res.z_new, res.z_new, e.w));
    res.fin = e.last;
    return res;
  endfunction

  function automatic update_res_t mk_result(
    input logic signed [DATA_W-1:0] rn,
    input logic signed [DATA_W-1:0] zn,
    input logic signed [SUM_W-1:0]  rz,
    input logic signed [SUM_W-1:0]  zz,
    input logic                     fin
  );
    update_res_t res;
    res.r_new = rn;
    res.z_new = zn;
    res.rz = rz;
    res.zz = zz;
    res.fin = fin;
    return res;
  endfunction

  function automatic vec_entry_t mk_entry(
    input logic signed [DATA_W-1:0] r,
    input logic signed [DATA_W-1:0] z,
    input logic signed [DATA_W-1:0] s,
    input logic signed [DATA_W-1:0] sd,
    input logic [WEIGHT_W-1:0]      w,
    input logic                     last
  );
    vec_entry_t e;
    e.r = r;
    e.z = z;
    e.s = s;
    e.sd = sd;
    e.w = w;
    e.last = last;
    e.typed = 1'b0;
    e.want = NO_RESULT;
    return e;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(9)) inside
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      [2:4]: return $urandom;
      default: return $urandom_range(0, 4194304) - 2097152;
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9)) inside
      0: return '0;
      1: return 17'd65536;
      2: return WEIGHT_W'($urandom_range(65537, 131071));
      default: return WEIGHT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_row(
    input bit                       set_a,
    input logic signed [DATA_W-1:0] a,
    input vec_entry_t               e,
    input bit                       typed,
    input update_res_t              want
  );
    stim_row_t row;
    row.set_alpha = set_a;
    row.alpha = a;
    row.e = e;
    row.e.typed = typed;
    row.e.want = want;
    stim_table.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // waits until nothing is in flight, then writes alpha
  task automatic apply_step(input logic signed [DATA_W-1:0] val);
    do @(negedge clk);
    while (pending_entries.size() != 0 || items_ch.valid || expected_updates.size() != 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    step_alpha = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // item source and prediction on acceptance
  always @(posedge clk) begin : item_drive
    if (rst) begin
      items_ch.valid <= 1'b0;
      items_ch.residual_in <= '0;
      items_ch.precond_in <= '0;
      items_ch.dir_in <= '0;
      items_ch.precond_dir_in <= '0;
      items_ch.inv_degree <= '0;
      items_ch.last_item <= 1'b0;
      rz_run = '0;
      zz_run = '0;
    end else begin
      if (items_ch.valid && items_ch.ready) begin
        accepted_res = predict_update(cur_entry, step_alpha, rz_run, zz_run);
        if (accepted_res.fin) begin
          rz_run = '0;
          zz_run = '0;
        end else begin
          rz_run = accepted_res.rz;
          zz_run = accepted_res.zz;
        end
        expected_updates.push_back(cur_entry.typed ? cur_entry.want : accepted_res);
      end
      if (!items_ch.valid || items_ch.ready) begin
        if (pending_entries.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_entry = pending_entries.pop_front();
          items_ch.valid <= 1'b1;
          items_ch.residual_in <= cur_entry.r;
          items_ch.precond_in <= cur_entry.z;
          items_ch.dir_in <= cur_entry.s;
          items_ch.precond_dir_in <= cur_entry.sd;
          items_ch.inv_degree <= cur_entry.w;
          items_ch.last_item <= cur_entry.last;
        end else begin
          items_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and field compare
  always @(posedge clk) begin : result_check
    update_res_t want;
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        if (expected_updates.size() == 0) begin
          flag_mismatch("unexpected transaction", 64'(results_ch.sums_final), '0);
        end else begin
          want = expected_updates.pop_front();
          if (results_ch.residual_out !== want.r_new)
            flag_mismatch("residual_out", 64'(results_ch.residual_out), 64'(want.r_new));
          if (results_ch.precond_out !== want.z_new)
            flag_mismatch("precond_out", 64'(results_ch.precond_out), 64'(want.z_new));
          if (results_ch.rz_sum !== want.rz)
            flag_mismatch("rz_sum", results_ch.rz_sum, want.rz);
          if (results_ch.zz_sum !== want.zz)
            flag_mismatch("zz_sum", results_ch.zz_sum, want.zz);
          if (results_ch.sums_final !== want.fin)
            flag_mismatch("sums_final", 64'(results_ch.sums_final), 64'(want.fin));
        end
      end
      results_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : main_seq
    logic signed [DATA_W-1:0] phase_alpha[7];
    vec_entry_t e;
    int n;
    int len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    step_alpha = '0;
    calm = 1'b0;

    // alpha still at its reset value for the first rows
    add_row(0, 0, mk_entry(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 17'd65536, 1), 1,
            mk_result(0, 0, 0, 0, 1));
    add_row(0, 0, mk_entry(32'sh1_0000, 32'sh1_0000, 0, 0, 17'd65536, 1), 1,
            mk_result(32'sh1_0000, 32'sh1_0000, 64'sh1_0000_0000, 64'sh1_0000_0000, 1));
    add_row(0, 0, mk_entry(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 17'd65536, 1), 1,
            mk_result(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 64'sh3FFF_FFFF_0000_0001,
                      64'sh3FFF_FFFF_0000_0001, 1));
    // max weight on the largest product, then accumulator saturation
    add_row(0, 0, mk_entry(32'sh8000_0000, 32'sh8000_0000, 0, 0, 17'h1FFFF, 0), 1,
            mk_result(32'sh8000_0000, 32'sh8000_0000, 64'sh7FFF_C000_0000_0000,
                      64'sh7FFF_C000_0000_0000, 0));
    add_row(0, 0, mk_entry(32'sh8000_0000, 32'sh8000_0000, 0, 0, 17'h1FFFF, 1), 1,
            mk_result(32'sh8000_0000, 32'sh8000_0000, SUM_MAX, SUM_MAX, 1));
    add_row(0, 0, mk_entry(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 17'h1FFFF, 0), 0, NO_RESULT);
    add_row(0, 0, mk_entry(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 17'h1FFFF, 1), 0, NO_RESULT);
    // weight rounding, half away from zero
    add_row(0, 0, mk_entry(1, 1, 0, 0, 17'd32768, 0), 0, NO_RESULT);
    add_row(0, 0, mk_entry(-1, 1, 0, 0, 17'd32768, 1), 0, NO_RESULT);
    add_row(0, 0, mk_entry(32'sh1234_5678, -32'sh0765_4321, 0, 0, 17'd0, 1), 0, NO_RESULT);
    // step rounding at the half point
    add_row(1, 1, mk_entry(100, 100, 32768, -32768, 17'd65536, 0), 0, NO_RESULT);
    add_row(0, 0, mk_entry(100, 100, 32767, -32767, 17'd65536, 1), 0, NO_RESULT);
    // unit step with update clamping both ways
    add_row(1, 32'sh1_0000,
            mk_entry(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 17'd0, 1),
            1, mk_result(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1));
    add_row(0, 0, mk_entry(32'sh1234_5678, 32'sh0BCD_EF01, 32'sh0001_8000, -32'sh0002_4000,
                           17'd49152, 1), 0, NO_RESULT);
    add_row(1, -32'sh1_0000, mk_entry(32'sh03E8_0000, -32'sh0010_0000, 32'sh0000_8000,
                                      32'sh0003_0000, 17'd65536, 0), 0, NO_RESULT);
    add_row(0, 0, mk_entry(-32'sh0001_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000,
                           17'd70000, 1), 0, NO_RESULT);
    add_row(1, 32'sh7FFF_FFFF,
            mk_entry(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 17'd65536, 1), 0, NO_RESULT);
    add_row(1, 32'sh8000_0000,
            mk_entry(0, 0, 32'sh8000_0000, 32'sh8000_0000, 17'd65536, 0), 0, NO_RESULT);
    add_row(0, 0, mk_entry(5, -5, 1, -1, 17'd65535, 1), 0, NO_RESULT);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].set_alpha) apply_step(stim_table[i].alpha);
      pending_entries.push_back(stim_table[i].e);
    end

    phase_alpha[0] = 32'sh1_0000;
    phase_alpha[1] = $urandom_range(0, 131072) - 65536;
    phase_alpha[2] = $urandom;
    phase_alpha[3] = 32'sh7FFF_FFFF;
    phase_alpha[4] = 32'sh8000_0000;
    phase_alpha[5] = $urandom_range(0, 32768) - 16384;
    phase_alpha[6] = 0;

    for (int ph = 0; ph < 7; ph++) begin
      apply_step(phase_alpha[ph]);
      calm = (ph == 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++) begin
          e = mk_entry(rand_word(), rand_word(), rand_word(), rand_word(), rand_weight(),
                       k == len - 1);
          // broken vectors: a stray or missing close
          if ($urandom_range(9) == 0) e.last = 1'($urandom_range(1));
          pending_entries.push_back(e);
          n++;
        end
      end
    end

    do @(negedge clk);
    while (pending_entries.size() != 0 || items_ch.valid || expected_updates.size() != 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
